FILE: sv/lavm_pkg.sv
// ----------------------------------------------------------------------------
// lavm_pkg: shared types and constants of the look-at view matrix core
// Holds the item formats passed between the front, the queue, the solver
// and the row emitter, plus the fixed datapath widths.
// ----------------------------------------------------------------------------
package lavm_pkg;

    // Largest supported fraction width; internal widths are sized for it
    localparam int FRAC_MAX = 24;

    // Axis component width: unit-length components reach 2^FRAC
    localparam int AXW  = FRAC_MAX + 3;
    // Magnitude register width: cross products reach 2^56
    localparam int MAGW = 58;
    // Accumulator width
    localparam int ACCW = 64;
    // Shared multiplier operand width
    localparam int MULW = 33;
    // Quotient width of the divide loop
    localparam int QW   = FRAC_MAX + 2;

    typedef logic [2:0][31:0]     vec32_t;
    typedef logic [2:0][32:0]     vecd_t;
    typedef logic [2:0][AXW-1:0]  vecax_t;

    // One camera update after the front: eye, up and direction to target
    typedef struct packed {
        vec32_t eye;
        vec32_t up;
        vecd_t  dir;
    } job_t;

    // Solved camera: the three axes, translation terms and degenerate flag
    typedef struct packed {
        vecax_t ax_x;
        vecax_t ax_y;
        vecax_t ax_z;
        vec32_t trans;
        logic   degen;
    } res_t;

endpackage

FILE: sv/lavm_front.sv
// ----------------------------------------------------------------------------
// lavm_front: input stage
// Accepts one camera item, forms the direction target - eye and holds the
// result in a register until the queue takes it.
// ----------------------------------------------------------------------------
module lavm_front
    import lavm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [31:0]  eye_x,
    input  logic [31:0]  eye_y,
    input  logic [31:0]  eye_z,
    input  logic [31:0]  target_x,
    input  logic [31:0]  target_y,
    input  logic [31:0]  target_z,
    input  logic [31:0]  up_x,
    input  logic [31:0]  up_y,
    input  logic [31:0]  up_z,
    output logic         job_valid,
    input  logic         job_ready,
    output job_t         job
);

    logic valid_reg;
    job_t job_reg;
    job_t job_next;

    assign in_ready  = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        job_next.eye    = {eye_z, eye_y, eye_x};
        job_next.up     = {up_z, up_y, up_x};
        job_next.dir[0] = {target_x[31], target_x} - {eye_x[31], eye_x};
        job_next.dir[1] = {target_y[31], target_y} - {eye_y[31], eye_y};
        job_next.dir[2] = {target_z[31], target_z} - {eye_z[31], eye_z};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            job_reg <= job_next;
        end
    end

endmodule

FILE: sv/lavm_queue.sv
// ----------------------------------------------------------------------------
// lavm_queue: two-entry item queue
// Decouples the front from the solver so each side stalls on its own.
// ----------------------------------------------------------------------------
module lavm_queue
    import lavm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  job_t  push_job,
    output logic  pop_valid,
    input  logic  pop_ready,
    output job_t  pop_job
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: sv/lavm_solve.sv
// ----------------------------------------------------------------------------
// lavm_solve: camera axis solver
// Sequencer around one shared multiplier, a bit-pair square root loop and
// a restoring divide loop. Builds forward, right and up axes and the
// translation terms for one item at a time.
// ----------------------------------------------------------------------------
module lavm_solve
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  job_valid,
    output logic  job_ready,
    input  job_t  job,
    output logic  res_valid,
    input  logic  res_ready,
    output res_t  res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_DIVI  = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [2:0] SRC_MAG = 3'd0;
    localparam logic [2:0] SRC_UP  = 3'd1;
    localparam logic [2:0] SRC_EYE = 3'd2;
    localparam logic [2:0] SRC_Z   = 3'd3;
    localparam logic [2:0] SRC_X   = 3'd4;
    localparam logic [2:0] SRC_Y   = 3'd5;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_SUB  = 2'd2;

    localparam logic [2:0] DST_NONE  = 3'd0;
    localparam logic [2:0] DST_SUM   = 3'd1;
    localparam logic [2:0] DST_CROSS = 3'd2;
    localparam logic [2:0] DST_Y     = 3'd3;
    localparam logic [2:0] DST_T     = 3'd4;

    localparam logic [4:0] OP_CROSS = 5'd3;
    localparam logic [4:0] OP_UPAX  = 5'd9;

    localparam logic [MAGW-1:0] HI_COARSE = MAGW'(1) << 38;
    localparam logic [MAGW-1:0] HI_FINE   = MAGW'(1) << 30;
    localparam logic [MAGW-1:0] LO_COARSE = MAGW'(1) << 21;
    localparam logic [MAGW-1:0] LO_FINE   = MAGW'(1) << 29;

    typedef struct packed {
        logic [2:0] a_src;
        logic [1:0] a_idx;
        logic [2:0] b_src;
        logic [1:0] b_idx;
        logic [1:0] mode;
        logic [2:0] dst;
        logic [1:0] d_idx;
    } op_t;

    // Multiply-accumulate program: squares, cross, up axis, translation
    function automatic op_t op_decode(input logic [4:0] op);
        op_t o;
        case (op)
            5'd0:  o = '{SRC_MAG, 2'd0, SRC_MAG, 2'd0, MODE_LOAD, DST_NONE,  2'd0};
            5'd1:  o = '{SRC_MAG, 2'd1, SRC_MAG, 2'd1, MODE_ADD,  DST_NONE,  2'd0};
            5'd2:  o = '{SRC_MAG, 2'd2, SRC_MAG, 2'd2, MODE_ADD,  DST_SUM,   2'd0};
            5'd3:  o = '{SRC_UP,  2'd1, SRC_Z,   2'd2, MODE_LOAD, DST_NONE,  2'd0};
            5'd4:  o = '{SRC_UP,  2'd2, SRC_Z,   2'd1, MODE_SUB,  DST_CROSS, 2'd0};
            5'd5:  o = '{SRC_UP,  2'd2, SRC_Z,   2'd0, MODE_LOAD, DST_NONE,  2'd0};
            5'd6:  o = '{SRC_UP,  2'd0, SRC_Z,   2'd2, MODE_SUB,  DST_CROSS, 2'd1};
            5'd7:  o = '{SRC_UP,  2'd0, SRC_Z,   2'd1, MODE_LOAD, DST_NONE,  2'd0};
            5'd8:  o = '{SRC_UP,  2'd1, SRC_Z,   2'd0, MODE_SUB,  DST_CROSS, 2'd2};
            5'd9:  o = '{SRC_Z,   2'd1, SRC_X,   2'd2, MODE_LOAD, DST_NONE,  2'd0};
            5'd10: o = '{SRC_Z,   2'd2, SRC_X,   2'd1, MODE_SUB,  DST_Y,     2'd0};
            5'd11: o = '{SRC_Z,   2'd2, SRC_X,   2'd0, MODE_LOAD, DST_NONE,  2'd0};
            5'd12: o = '{SRC_Z,   2'd0, SRC_X,   2'd2, MODE_SUB,  DST_Y,     2'd1};
            5'd13: o = '{SRC_Z,   2'd0, SRC_X,   2'd1, MODE_LOAD, DST_NONE,  2'd0};
            5'd14: o = '{SRC_Z,   2'd1, SRC_X,   2'd0, MODE_SUB,  DST_Y,     2'd2};
            5'd15: o = '{SRC_X,   2'd0, SRC_EYE, 2'd0, MODE_LOAD, DST_NONE,  2'd0};
            5'd16: o = '{SRC_X,   2'd1, SRC_EYE, 2'd1, MODE_ADD,  DST_NONE,  2'd0};
            5'd17: o = '{SRC_X,   2'd2, SRC_EYE, 2'd2, MODE_ADD,  DST_T,     2'd0};
            5'd18: o = '{SRC_Y,   2'd0, SRC_EYE, 2'd0, MODE_LOAD, DST_NONE,  2'd0};
            5'd19: o = '{SRC_Y,   2'd1, SRC_EYE, 2'd1, MODE_ADD,  DST_NONE,  2'd0};
            5'd20: o = '{SRC_Y,   2'd2, SRC_EYE, 2'd2, MODE_ADD,  DST_T,     2'd1};
            5'd21: o = '{SRC_Z,   2'd0, SRC_EYE, 2'd0, MODE_LOAD, DST_NONE,  2'd0};
            5'd22: o = '{SRC_Z,   2'd1, SRC_EYE, 2'd1, MODE_ADD,  DST_NONE,  2'd0};
            5'd23: o = '{SRC_Z,   2'd2, SRC_EYE, 2'd2, MODE_ADD,  DST_T,     2'd2};
            default: o = '{SRC_MAG, 2'd0, SRC_MAG, 2'd0, MODE_LOAD, DST_NONE, 2'd0};
        endcase
        return o;
    endfunction

    function automatic logic signed [MULW-1:0] pick(
        input logic [2:0]            src,
        input logic [1:0]            idx,
        input logic [2:0][MAGW-1:0]  mag,
        input vec32_t                upv,
        input vec32_t                eyev,
        input vecax_t                zv,
        input vecax_t                xv,
        input vecax_t                yv
    );
        logic signed [MULW-1:0] v;
        case (src)
            SRC_MAG: v = {3'b000, mag[idx][29:0]};
            SRC_UP:  v = {upv[idx][31], upv[idx]};
            SRC_EYE: v = {eyev[idx][31], eyev[idx]};
            SRC_Z:   v = {{(MULW-AXW){zv[idx][AXW-1]}}, zv[idx]};
            SRC_X:   v = {{(MULW-AXW){xv[idx][AXW-1]}}, xv[idx]};
            SRC_Y:   v = {{(MULW-AXW){yv[idx][AXW-1]}}, yv[idx]};
            default: v = '0;
        endcase
        return v;
    endfunction

    // Control
    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [4:0]  op_reg;
    logic [5:0]  cnt_reg;
    logic [1:0]  comp_reg;
    logic        pass_reg;
    logic        degen_reg;

    // Datapath
    vec32_t                  eye_reg;
    vec32_t                  up_reg;
    logic [2:0][MAGW-1:0]    mag_reg;
    logic [2:0]              neg_reg;
    vecax_t                  z_reg;
    vecax_t                  x_reg;
    vecax_t                  y_reg;
    vec32_t                  t_reg;
    logic signed [ACCW-1:0]  prod_reg;
    logic signed [ACCW-1:0]  acc_reg;
    logic [ACCW-1:0]         sq_n_reg;
    logic [ACCW-1:0]         sq_res_reg;
    logic [ACCW-1:0]         sq_bit_reg;
    logic [31:0]             len_reg;
    logic [ACCW-1:0]         rem_reg;
    logic [ACCW-1:0]         den_reg;
    logic [QW-1:0]           quot_reg;

    op_t                     op_cur;
    logic signed [MULW-1:0]  mul_a;
    logic signed [MULW-1:0]  mul_b;
    logic signed [2*MULW-1:0] prod_full;
    logic signed [ACCW-1:0]  acc_next;
    logic [ACCW-1:0]         acc_mag;
    logic [ACCW-1:0]         rnd_mag;
    logic [AXW-1:0]          y_val;
    logic [31:0]             t_val;
    logic [MAGW-1:0]         mx;
    logic                    mx_zero;
    logic [2:0][MAGW-1:0]    mag_scaled;
    logic                    scale_done;
    logic [ACCW-1:0]         sq_try;
    logic                    sq_ge;
    logic [ACCW-1:0]         sq_res_new;
    logic                    div_ge;
    logic [QW-1:0]           quot_new;
    logic [AXW-1:0]          ax_val;

    assign job_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.ax_x  = x_reg;
        res.ax_y  = y_reg;
        res.ax_z  = z_reg;
        res.trans = t_reg;
        res.degen = degen_reg;
    end

    // Shared multiply-accumulate
    always_comb
    begin
        op_cur    = op_decode(op_reg);
        mul_a     = pick(op_cur.a_src, op_cur.a_idx, mag_reg, up_reg, eye_reg,
                         z_reg, x_reg, y_reg);
        mul_b     = pick(op_cur.b_src, op_cur.b_idx, mag_reg, up_reg, eye_reg,
                         z_reg, x_reg, y_reg);
        prod_full = mul_a * mul_b;
        case (op_cur.mode)
            MODE_LOAD: acc_next = prod_reg;
            MODE_ADD:  acc_next = acc_reg + prod_reg;
            MODE_SUB:  acc_next = acc_reg - prod_reg;
            default:   acc_next = prod_reg;
        endcase
        acc_mag = acc_next[ACCW-1] ? ACCW'(-acc_next) : ACCW'(acc_next);
        rnd_mag = (acc_mag + (ACCW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        y_val   = acc_next[ACCW-1] ? AXW'(-rnd_mag) : AXW'(rnd_mag);
        // Translation is the negated, rounded dot product, clamped to 32 bits
        if (acc_next[ACCW-1])
        begin
            t_val = (rnd_mag > ACCW'(32'h7fff_ffff)) ? 32'h7fff_ffff : rnd_mag[31:0];
        end
        else
        begin
            t_val = (rnd_mag > ACCW'(32'h8000_0000)) ? 32'h8000_0000
                                                     : 32'(-rnd_mag);
        end
    end

    // Normalizing shift: coarse and fine steps until max lies in [2^29, 2^30)
    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx)
        begin
            mx = mag_reg[1];
        end
        if (mag_reg[2] > mx)
        begin
            mx = mag_reg[2];
        end
        mx_zero    = (mx == '0);
        scale_done = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (mx >= HI_COARSE)
            begin
                mag_scaled[i] = mag_reg[i] >> 8;
            end
            else if (mx >= HI_FINE)
            begin
                mag_scaled[i] = mag_reg[i] >> 1;
            end
            else if (mx < LO_COARSE)
            begin
                mag_scaled[i] = mag_reg[i] << 8;
            end
            else if (mx < LO_FINE)
            begin
                mag_scaled[i] = mag_reg[i] << 1;
            end
            else
            begin
                mag_scaled[i] = mag_reg[i];
            end
        end
        if (mx < HI_FINE && mx >= LO_FINE)
        begin
            scale_done = 1'b1;
        end
    end

    // Square root and divide steps
    always_comb
    begin
        sq_try     = sq_res_reg + sq_bit_reg;
        sq_ge      = (sq_n_reg >= sq_try);
        sq_res_new = sq_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);
        div_ge     = (rem_reg >= den_reg);
        quot_new   = {quot_reg[QW-2:0], div_ge};
        ax_val     = neg_reg[comp_reg] ? AXW'(-{1'b0, quot_new})
                                       : AXW'({1'b0, quot_new});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (mx_zero)
                begin
                    state_next = S_MUL;
                end
                else if (scale_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (op_cur.dst == DST_SUM)
                begin
                    state_next = S_SQRT;
                end
                else if (op_cur.dst == DST_CROSS && op_cur.d_idx == 2'd2)
                begin
                    state_next = S_SCALE;
                end
                else if (op_cur.dst == DST_T && op_cur.d_idx == 2'd2)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_SQRT:
            begin
                if (cnt_reg == 6'd0)
                begin
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == 6'd0)
                begin
                    state_next = (comp_reg == 2'd2) ? S_MUL : S_DIVI;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= 5'd0;
            cnt_reg   <= 6'd0;
            comp_reg  <= 2'd0;
            pass_reg  <= 1'b0;
            degen_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    pass_reg  <= 1'b0;
                    degen_reg <= 1'b0;
                    op_reg    <= 5'd0;
                end
                S_SCALE:
                begin
                    if (mx_zero)
                    begin
                        degen_reg <= 1'b1;
                        op_reg    <= pass_reg ? OP_UPAX : OP_CROSS;
                    end
                    else if (scale_done)
                    begin
                        op_reg <= 5'd0;
                    end
                end
                S_ACC:
                begin
                    if (op_cur.dst == DST_SUM)
                    begin
                        cnt_reg <= 6'd31;
                    end
                    else if (op_cur.dst == DST_CROSS && op_cur.d_idx == 2'd2)
                    begin
                        pass_reg <= 1'b1;
                    end
                    else if (!(op_cur.dst == DST_T && op_cur.d_idx == 2'd2))
                    begin
                        op_reg <= op_reg + 5'd1;
                    end
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        comp_reg <= 2'd0;
                    end
                end
                S_DIVI:
                begin
                    cnt_reg <= 6'(FRAC_BITS);
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        comp_reg <= comp_reg + 2'd1;
                        if (comp_reg == 2'd2)
                        begin
                            op_reg <= pass_reg ? OP_UPAX : OP_CROSS;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[ACCW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    eye_reg <= job.eye;
                    up_reg  <= job.up;
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_reg[i] <= job.dir[i][32];
                        mag_reg[i] <= job.dir[i][32]
                                      ? {{(MAGW-33){1'b0}}, -job.dir[i]}
                                      : {{(MAGW-33){1'b0}}, job.dir[i]};
                    end
                end
            end
            S_SCALE:
            begin
                mag_reg <= mag_scaled;
                if (mx_zero)
                begin
                    if (pass_reg)
                    begin
                        x_reg <= '0;
                    end
                    else
                    begin
                        z_reg <= '0;
                    end
                end
            end
            S_ACC:
            begin
                acc_reg <= acc_next;
                case (op_cur.dst)
                    DST_SUM:
                    begin
                        sq_n_reg   <= ACCW'(acc_next);
                        sq_res_reg <= '0;
                        sq_bit_reg <= ACCW'(1) << 62;
                    end
                    DST_CROSS:
                    begin
                        neg_reg[op_cur.d_idx] <= acc_next[ACCW-1];
                        mag_reg[op_cur.d_idx] <= acc_mag[MAGW-1:0];
                    end
                    DST_Y:
                    begin
                        y_reg[op_cur.d_idx] <= y_val;
                    end
                    DST_T:
                    begin
                        t_reg[op_cur.d_idx] <= t_val;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_n_reg <= sq_n_reg - sq_try;
                end
                sq_res_reg <= sq_res_new;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (cnt_reg == 6'd0)
                begin
                    len_reg <= sq_res_new[31:0];
                end
            end
            S_DIVI:
            begin
                rem_reg  <= (ACCW'(mag_reg[comp_reg][29:0]) << FRAC_BITS)
                            + ACCW'(len_reg >> 1);
                den_reg  <= ACCW'(len_reg) << FRAC_BITS;
                quot_reg <= '0;
            end
            S_DIV:
            begin
                if (div_ge)
                begin
                    rem_reg <= rem_reg - den_reg;
                end
                den_reg  <= den_reg >> 1;
                quot_reg <= quot_new;
                if (cnt_reg == 6'd0)
                begin
                    if (pass_reg)
                    begin
                        x_reg[comp_reg] <= ax_val;
                    end
                    else
                    begin
                        z_reg[comp_reg] <= ax_val;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: sv/lavm_emit.sv
// ----------------------------------------------------------------------------
// lavm_emit: matrix row emitter
// Holds one solved camera and sends its eight rows, view matrix first,
// then the billboard matrix. Takes the next camera as the last row leaves.
// ----------------------------------------------------------------------------
module lavm_emit
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         res_valid,
    output logic         res_ready,
    input  res_t         res,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         matrix_select,
    output logic [1:0]   row_index,
    output logic [31:0]  col0,
    output logic [31:0]  col1,
    output logic [31:0]  col2,
    output logic [31:0]  col3,
    output logic         degenerate,
    output logic         last_row
);

    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic       busy_reg;
    logic [2:0] row_reg;
    res_t       res_reg;
    logic       out_take;
    logic       res_take;
    vec32_t     xs;
    vec32_t     ys;
    vec32_t     zs;

    assign last_row      = (row_reg == 3'd7);
    assign out_valid     = busy_reg;
    assign out_take      = out_valid && out_ready;
    assign res_ready     = !busy_reg || (out_take && last_row);
    assign res_take      = res_valid && res_ready;
    assign matrix_select = row_reg[2];
    assign row_index     = row_reg[1:0];
    assign degenerate    = res_reg.degen;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            xs[i] = {{(32-AXW){res_reg.ax_x[i][AXW-1]}}, res_reg.ax_x[i]};
            ys[i] = {{(32-AXW){res_reg.ax_y[i][AXW-1]}}, res_reg.ax_y[i]};
            zs[i] = {{(32-AXW){res_reg.ax_z[i][AXW-1]}}, res_reg.ax_z[i]};
        end
        case (row_reg)
            3'd0, 3'd1, 3'd2:
            begin
                col0 = xs[row_reg[1:0]];
                col1 = ys[row_reg[1:0]];
                col2 = zs[row_reg[1:0]];
                col3 = '0;
            end
            3'd3:
            begin
                col0 = res_reg.trans[0];
                col1 = res_reg.trans[1];
                col2 = res_reg.trans[2];
                col3 = ONE;
            end
            3'd4:
            begin
                col0 = xs[0];
                col1 = xs[1];
                col2 = xs[2];
                col3 = '0;
            end
            3'd5:
            begin
                col0 = ys[0];
                col1 = ys[1];
                col2 = ys[2];
                col3 = '0;
            end
            3'd6:
            begin
                col0 = zs[0];
                col1 = zs[1];
                col2 = zs[2];
                col3 = '0;
            end
            default:
            begin
                col0 = '0;
                col1 = '0;
                col2 = '0;
                col3 = ONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= 3'd0;
        end
        else if (res_take)
        begin
            busy_reg <= 1'b1;
            row_reg  <= 3'd0;
        end
        else if (out_take)
        begin
            if (last_row)
            begin
                busy_reg <= 1'b0;
            end
            row_reg <= row_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: sv/look_at_view_matrix_core.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_core: left-handed look-at camera
// Turns eye, target and up vectors into a view matrix and a billboard
// matrix, sent as eight rows of four fixed-point words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one camera item: eye, target and
//   up in signed fixed point with FRAC_BITS fraction bits.
//   Output channel (out_valid/out_ready) returns eight row items per camera:
//   rows 0..3 of the view matrix, then rows 0..3 of the billboard matrix.
//   last_row marks the eighth; degenerate is set on all eight rows when the
//   forward or right axis has zero length, and that axis reads as zero.
//   The solve time is set by the shared multiplier, the 32-step square root
//   loop run twice and the FRAC_BITS + 1 step divide loop run six times per
//   camera; the solver takes one camera at a time. The front register and
//   a two-entry queue take up to three further cameras while one is being
//   solved.
//   Receiver stall: rows hold steady; the solver keeps a finished camera
//   until the emitter frees up, then the queue fills and in_ready drops.
//   Reset: all pipeline and queue contents are dropped; no row is pending.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core
    import lavm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [31:0]  eye_x,
    input  logic [31:0]  eye_y,
    input  logic [31:0]  eye_z,
    input  logic [31:0]  target_x,
    input  logic [31:0]  target_y,
    input  logic [31:0]  target_z,
    input  logic [31:0]  up_x,
    input  logic [31:0]  up_y,
    input  logic [31:0]  up_z,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         matrix_select,
    output logic [1:0]   row_index,
    output logic [31:0]  col0,
    output logic [31:0]  col1,
    output logic [31:0]  col2,
    output logic [31:0]  col3,
    output logic         degenerate,
    output logic         last_row
);

    // front -> queue
    logic f_valid;
    logic f_ready;
    job_t f_job;

    // queue -> solver
    logic q_valid;
    logic q_ready;
    job_t q_job;

    // solver -> emitter
    logic s_valid;
    logic s_ready;
    res_t s_res;

    // Accept the item and form the direction vector
    lavm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .eye_x     (eye_x),
        .eye_y     (eye_y),
        .eye_z     (eye_z),
        .target_x  (target_x),
        .target_y  (target_y),
        .target_z  (target_z),
        .up_x      (up_x),
        .up_y      (up_y),
        .up_z      (up_z),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    // Buffer items so the front keeps taking input while the solver works
    lavm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_job    (q_job)
    );

    // Solve axes and translation terms
    lavm_solve #(
        .FRAC_BITS (FRAC_BITS)
    ) u_solve (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .res_valid (s_valid),
        .res_ready (s_ready),
        .res       (s_res)
    );

    // Send the eight rows
    lavm_emit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (s_valid),
        .res_ready     (s_ready),
        .res           (s_res),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .matrix_select (matrix_select),
        .row_index     (row_index),
        .col0          (col0),
        .col1          (col1),
        .col2          (col2),
        .col3          (col3),
        .degenerate    (degenerate),
        .last_row      (last_row)
    );

endmodule
